// File: rtl/expression_token_scanner_top_defines.svh
// Assertion macros shared by the expression token scanner RTL.
`ifndef EXPRESSION_TOKEN_SCANNER_TOP_DEFINES_SVH
`define EXPRESSION_TOKEN_SCANNER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ETS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ETS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/ets_pkg.sv
// Types and constants shared by the expression token scanner modules.
package ets_pkg;

	// Token kinds as they appear on the result channel.
	typedef enum logic [2:0] {
		TK_NUMBER   = 3'd0,
		TK_VARIABLE = 3'd1,
		TK_FUNCTION = 3'd2,
		TK_OPERATOR = 3'd3,
		TK_NEGATION = 3'd4,
		TK_OPEN     = 3'd5,
		TK_CLOSE    = 3'd6,
		TK_DELIM    = 3'd7
	} tok_kind_t;

	// Kind of the multi-character token currently being collected.
	typedef enum logic [1:0] {
		OPEN_NONE  = 2'd0,
		OPEN_NUM   = 2'd1,
		OPEN_IDENT = 2'd2
	} open_kind_t;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_DELIM = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POINT = 2'd1;

	// Configuration reset values.
	localparam logic [7:0] DELIM_RESET = 8'd44;
	localparam logic [7:0] POINT_RESET = 8'd46;

	// Character codes.
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_LC_A   = 8'h61;
	localparam logic [7:0] CH_LC_Z   = 8'h7A;
	localparam logic [7:0] CH_UC_A   = 8'h41;
	localparam logic [7:0] CH_UC_Z   = 8'h5A;

	// Request from the scanner to load its result records into the queue.
	typedef struct packed {
		logic       go;
		logic [1:0] count;
	} res_load_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= CH_LC_A) && (c <= CH_LC_Z)) || ((c >= CH_UC_A) && (c <= CH_UC_Z));
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB);
	endfunction

endpackage

// File: rtl/expression_token_scanner_top.sv
// Top level of the expression token scanner.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+------------------------------------------------
//  in       | in_valid / in_stall  | char_code, line_end
//  out      | out_valid / out_stall| token_kind, start_offset, token_length,
//           |                      | length_clipped, last_of_run
//  cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
//
// One character per cycle while in_stall is low: a character is scanned in the
// input register, and its zero to two records load the result queue as it leaves.
// The queue drains one record per cycle while out_stall is low, so two queued
// records stall the input. An output stall backs up into in_stall once the input
// register is occupied. Reset clears the line state.
`include "expression_token_scanner_top_defines.svh"

module expression_token_scanner_top #(
	parameter int MAX_TOKEN_LEN = 63,
	parameter int MAX_LINE      = 4096,
	localparam int LEN_W        = $clog2(MAX_TOKEN_LEN + 1),
	localparam int POS_W        = $clog2(MAX_LINE)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    char_code,
	input  logic                          line_end,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [2:0]                    token_kind,
	output logic [POS_W-1:0]              start_offset,
	output logic [LEN_W-1:0]              token_length,
	output logic                          length_clipped,
	output logic                          last_of_run,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ets_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data
);
	import ets_pkg::*;

	localparam int REC_W = 3 + POS_W + LEN_W + 2;

	res_load_t        load;
	logic             free;
	logic [REC_W-1:0] rec0;
	logic [REC_W-1:0] rec1;
	logic [REC_W-1:0] out_rec;

	assign cfg_ready = 1'b1;

	// Scanner with its input register and state.
	ets_scan #(
		.MAX_TOKEN_LEN (MAX_TOKEN_LEN),
		.MAX_LINE      (MAX_LINE),
		.LEN_W         (LEN_W),
		.POS_W         (POS_W),
		.REC_W         (REC_W)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_code (char_code),
		.line_end  (line_end),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.free      (free),
		.load      (load),
		.rec0      (rec0),
		.rec1      (rec1)
	);

	// Result queue feeding the output channel.
	ets_resq #(
		.REC_W (REC_W)
	) u_resq (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.rec0      (rec0),
		.rec1      (rec1),
		.free      (free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_rec   (out_rec)
	);

	assign {token_kind, start_offset, token_length, length_clipped, last_of_run} = out_rec;

	// The queue is only loaded when it has room for the pair.
	`ETS_ASSERT_SAME(a_load_has_room, load.go, free, "queue loaded without room")
	// An empty queue can always take a load.
	`ETS_ASSERT_SAME(a_empty_is_free, !out_valid, free, "empty queue reported full")
	// Records loaded into the queue show up on the output next cycle.
	`ETS_ASSERT_NEXT(a_load_shows, load.go && (load.count != 2'd0), out_valid,
		"loaded records not presented")

endmodule

// File: rtl/ets_resq.sv
// Two-record result queue; hands token records out one per cycle unless stalled.
module ets_resq #(
	parameter int REC_W = 23
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ets_pkg::res_load_t   load,
	input  logic [REC_W-1:0]     rec0,
	input  logic [REC_W-1:0]     rec1,
	output logic                 free,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [REC_W-1:0]     out_rec
);
	import ets_pkg::*;

	logic [1:0]       cnt_q;
	logic [REC_W-1:0] rec0_q;
	logic [REC_W-1:0] rec1_q;
	logic             take;

	assign out_valid = (cnt_q != 2'd0);
	assign out_rec   = rec0_q;
	assign take      = out_valid && !out_stall;

	// Room for a new pair when empty or when the single record leaves now.
	assign free = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && take);

	// Record count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load.go) begin
			cnt_q <= load.count;
		end else if (take) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// Record storage; the second record moves up when the first is taken.
	always_ff @(posedge clk) begin
		if (load.go) begin
			rec0_q <= rec0;
			rec1_q <= rec1;
		end else if (take && (cnt_q == 2'd2)) begin
			rec0_q <= rec1_q;
		end
	end

endmodule

// File: rtl/ets_scan.sv
// Character input register, token scanning state and record formation.
module ets_scan #(
	parameter int MAX_TOKEN_LEN = 63,
	parameter int MAX_LINE      = 4096,
	parameter int LEN_W         = 6,
	parameter int POS_W         = 12,
	parameter int REC_W         = 3 + POS_W + LEN_W + 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    char_code,
	input  logic                          line_end,
	input  logic                          cfg_valid,
	input  logic [ets_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data,
	input  logic                          free,
	output ets_pkg::res_load_t            load,
	output logic [REC_W-1:0]              rec0,
	output logic [REC_W-1:0]              rec1
);
	import ets_pkg::*;

	localparam int BODY_W = REC_W - 1;
	localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(MAX_TOKEN_LEN);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_LINE - 1);

	// Input register.
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       end_s1;
	logic       accept;
	logic       advance;

	// Configuration registers.
	logic [7:0] delim_q;
	logic [7:0] point_q;

	// Scanner state.
	open_kind_t       open_kind_q;
	logic [POS_W-1:0] open_start_q;
	logic [LEN_W-1:0] open_len_q;
	logic             open_clip_q;
	logic [7:0]       prior_q;
	logic             seen_q;
	logic [POS_W-1:0] pos_q;

	// Next state.
	open_kind_t       n_kind;
	logic [POS_W-1:0] n_start;
	logic [LEN_W-1:0] n_len;
	logic             n_clip;
	logic [7:0]       n_prior;
	logic             n_seen;
	logic [POS_W-1:0] n_pos;

	// Character classes and record formation.
	logic             c_dig, c_pt, c_alpha, c_word, c_blank;
	logic             p_dig, p_alpha;
	logic             extend, close_a, start_new, emit_b, emit_c;
	tok_kind_t        a_kind, b_kind, c_kind;
	logic [BODY_W-1:0] body_a, body_b, body_c, slot0, slot1;
	logic [1:0]       rec_cnt;

	assign advance  = valid_s1 && free;
	assign in_stall = valid_s1 && !free;
	assign accept   = in_valid && !in_stall;

	// Input register holds one character until the queue can take its records.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= char_code;
			end_s1  <= line_end;
		end
	end

	// Configuration writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= DELIM_RESET;
			point_q <= POINT_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_DELIM) begin
				delim_q <= cfg_data;
			end
			if (cfg_index == CFG_POINT) begin
				point_q <= cfg_data;
			end
		end
	end

	assign c_dig   = is_digit(char_s1);
	assign c_pt    = (char_s1 == point_q);
	assign c_alpha = is_alpha(char_s1);
	assign c_word  = c_alpha || c_dig || (char_s1 == CH_UNDER);
	assign c_blank = is_blank(char_s1);
	assign p_dig   = is_digit(prior_q);
	assign p_alpha = is_alpha(prior_q);

	// Token scanning for one character, including the line end flush.
	always_comb begin
		n_kind    = open_kind_q;
		n_start   = open_start_q;
		n_len     = open_len_q;
		n_clip    = open_clip_q;
		n_prior   = prior_q;
		n_seen    = seen_q;
		extend    = 1'b0;
		close_a   = 1'b0;
		start_new = 1'b0;
		emit_b    = 1'b0;
		a_kind    = TK_NUMBER;
		b_kind    = TK_OPERATOR;

		// Decide whether the open token grows or ends.
		case (open_kind_q)
			OPEN_NUM: begin
				if (c_dig || c_pt) begin
					extend = 1'b1;
				end else begin
					close_a   = 1'b1;
					a_kind    = TK_NUMBER;
					start_new = 1'b1;
				end
			end
			OPEN_IDENT: begin
				if (char_s1 == CH_LPAREN) begin
					close_a   = 1'b1;
					a_kind    = TK_FUNCTION;
					start_new = 1'b1;
				end else if (c_word) begin
					extend = 1'b1;
				end else begin
					close_a   = 1'b1;
					a_kind    = TK_VARIABLE;
					start_new = 1'b1;
				end
			end
			default: begin
				start_new = 1'b1;
			end
		endcase

		// Growing token: length saturates and the clip flag records overflow.
		if (extend) begin
			if (open_len_q < LEN_MAX) begin
				n_len = open_len_q + LEN_W'(1);
			end else begin
				n_clip = 1'b1;
			end
			n_prior = char_s1;
		end

		if (close_a) begin
			n_kind  = OPEN_NONE;
			n_start = '0;
			n_len   = '0;
			n_clip  = 1'b0;
		end

		// A new token starts at this character unless it is blank.
		if (start_new && !c_blank) begin
			n_seen  = 1'b1;
			n_prior = char_s1;
			if (c_dig || c_pt || c_word) begin
				n_kind  = (c_dig || c_pt) ? OPEN_NUM : OPEN_IDENT;
				n_start = pos_q;
				n_len   = LEN_W'(1);
				n_clip  = 1'b0;
			end else begin
				emit_b = 1'b1;
				if (char_s1 == CH_LPAREN) begin
					b_kind = TK_OPEN;
				end else if (char_s1 == CH_RPAREN) begin
					b_kind = TK_CLOSE;
				end else if (char_s1 == delim_q) begin
					b_kind = TK_DELIM;
				end else if ((char_s1 == CH_MINUS) && (!seen_q ||
						(!p_alpha && !p_dig && (prior_q != CH_RPAREN)))) begin
					b_kind = TK_NEGATION;
				end else begin
					b_kind = TK_OPERATOR;
				end
			end
		end

		// Line end closes whatever is still open, then clears the line state.
		emit_c = end_s1 && (n_kind != OPEN_NONE);
		c_kind = (n_kind == OPEN_NUM) ? TK_NUMBER : TK_VARIABLE;
		body_c = {c_kind, n_start, n_len, n_clip};

		if (end_s1) begin
			n_kind  = OPEN_NONE;
			n_start = '0;
			n_len   = '0;
			n_clip  = 1'b0;
			n_prior = 8'd0;
			n_seen  = 1'b0;
			n_pos   = '0;
		end else if (pos_q != POS_LAST) begin
			n_pos = pos_q + POS_W'(1);
		end else begin
			n_pos = pos_q;
		end
	end

	assign body_a = {a_kind, open_start_q, open_len_q, open_clip_q};
	assign body_b = {b_kind, pos_q, LEN_W'(1), 1'b0};

	// Pack the records in order of emission; at most two are valid.
	assign rec_cnt = 2'(close_a) + 2'(emit_b) + 2'(emit_c);
	assign slot0   = close_a ? body_a : (emit_b ? body_b : body_c);
	assign slot1   = (close_a && emit_b) ? body_b : body_c;
	assign rec0    = {slot0, rec_cnt == 2'd1};
	assign rec1    = {slot1, 1'b1};

	assign load.go    = advance;
	assign load.count = rec_cnt;

	// State advances together with the queue load.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_kind_q  <= OPEN_NONE;
			open_start_q <= '0;
			open_len_q   <= '0;
			open_clip_q  <= 1'b0;
			prior_q      <= 8'd0;
			seen_q       <= 1'b0;
			pos_q        <= '0;
		end else if (advance) begin
			open_kind_q  <= n_kind;
			open_start_q <= n_start;
			open_len_q   <= n_len;
			open_clip_q  <= n_clip;
			prior_q      <= n_prior;
			seen_q       <= n_seen;
			pos_q        <= n_pos;
		end
	end

endmodule

// File: sim/tb_expression_token_scanner_top.sv
// Self-checking testbench for the expression token scanner, with its own token predictor.
module tb_expression_token_scanner_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ets_pkg::*;

	localparam int POS_W = 12;
	localparam int LEN_W = 6;
	localparam int TOKEN_CAP = 63;
	localparam int LINE_CAP = 4096;
	localparam int IDLE_PCT = 31;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES = 250;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

	typedef struct packed {
		logic [7:0] ch;
		logic       eol;
	} char_item_t;

	typedef struct packed {
		tok_kind_t          kind;
		logic [POS_W-1:0]   start;
		logic [LEN_W-1:0]   len;
		logic               clip;
		logic               last;
	} token_rec_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [7:0]           char_code = 8'd0;
	logic                 line_end = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [2:0]           token_kind;
	logic [POS_W-1:0]     start_offset;
	logic [LEN_W-1:0]     token_length;
	logic                 length_clipped;
	logic                 last_of_run;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_DELIM;
	logic [7:0]           cfg_data = 8'd0;

	expression_token_scanner_top u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.char_code      (char_code),
		.line_end       (line_end),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.token_kind     (token_kind),
		.start_offset   (start_offset),
		.token_length   (token_length),
		.length_clipped (length_clipped),
		.last_of_run    (last_of_run),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	// Characters waiting to be sent and token records waiting to come out.
	char_item_t chars_to_send[$];
	token_rec_t tokens_due[$];
	token_rec_t step_recs[$];
	logic [7:0] line_buf[$];

	// Predictor copy of the configuration and the line state.
	logic [7:0]       delim_code = DELIM_RESET;
	logic [7:0]       point_code = POINT_RESET;
	open_kind_t       cur_kind = OPEN_NONE;
	logic [POS_W-1:0] cur_start = '0;
	logic [LEN_W-1:0] cur_len = '0;
	logic             cur_clip = 1'b0;
	logic [7:0]       last_tok_char = 8'd0;
	logic             tok_seen = 1'b0;
	logic [POS_W-1:0] col = '0;

	// Run control and statistics.
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	bit hold_done = 1'b0;
	int hold_left = 0;
	int n_sent = 0;
	int n_lines = 0;
	int n_items = 0;
	int n_checked = 0;
	int n_clipped = 0;
	int n_errors = 0;
	int n_cfg_writes = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic bit digit_ch(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic bit letter_ch(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	endfunction

	function automatic bit space_ch(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB);
	endfunction

	task automatic push_record(input tok_kind_t k, input logic [POS_W-1:0] s,
			input logic [LEN_W-1:0] l, input logic clip);
		token_rec_t rec;
		rec.kind = k;
		rec.start = s;
		rec.len = l;
		rec.clip = clip;
		rec.last = 1'b0;
		step_recs.push_back(rec);
	endtask

	task automatic close_token(input tok_kind_t k);
		push_record(k, cur_start, cur_len, cur_clip);
		cur_kind = OPEN_NONE;
		cur_start = '0;
		cur_len = '0;
		cur_clip = 1'b0;
	endtask

	task automatic grow_token(input logic [7:0] c);
		if (cur_len < TOKEN_CAP) begin
			cur_len = cur_len + 1'b1;
		end else begin
			cur_clip = 1'b1;
		end
		last_tok_char = c;
	endtask

	// Opens a number or identifier, or emits a one-character token.
	task automatic begin_token(input logic [7:0] c, input logic [POS_W-1:0] pos);
		tok_kind_t k;
		if (space_ch(c)) begin
			return;
		end
		if (digit_ch(c) || c == point_code || letter_ch(c) || c == CH_UNDER) begin
			if (digit_ch(c) || c == point_code) begin
				cur_kind = OPEN_NUM;
			end else begin
				cur_kind = OPEN_IDENT;
			end
			cur_start = pos;
			cur_len = LEN_W'(1);
			cur_clip = 1'b0;
			tok_seen = 1'b1;
			last_tok_char = c;
			return;
		end
		if (c == CH_LPAREN) begin
			k = TK_OPEN;
		end else if (c == CH_RPAREN) begin
			k = TK_CLOSE;
		end else if (c == delim_code) begin
			k = TK_DELIM;
		end else if (c == CH_MINUS && (!tok_seen || (!letter_ch(last_tok_char) &&
				!digit_ch(last_tok_char) && last_tok_char != CH_RPAREN))) begin
			k = TK_NEGATION;
		end else begin
			k = TK_OPERATOR;
		end
		push_record(k, pos, LEN_W'(1), 1'b0);
		tok_seen = 1'b1;
		last_tok_char = c;
	endtask

	// Advances the predicted line state by one character and queues its records.
	task automatic scan_char(input logic [7:0] c, input logic eol);
		logic [POS_W-1:0] pos;
		token_rec_t rec;
		pos = col;
		step_recs.delete();
		case (cur_kind)
			OPEN_NUM: begin
				if (digit_ch(c) || c == point_code) begin
					grow_token(c);
				end else begin
					close_token(TK_NUMBER);
					begin_token(c, pos);
				end
			end
			OPEN_IDENT: begin
				if (c == CH_LPAREN) begin
					close_token(TK_FUNCTION);
					begin_token(c, pos);
				end else if (letter_ch(c) || digit_ch(c) || c == CH_UNDER) begin
					grow_token(c);
				end else begin
					close_token(TK_VARIABLE);
					begin_token(c, pos);
				end
			end
			default: begin
				begin_token(c, pos);
			end
		endcase
		if (pos < LINE_CAP - 1) begin
			col = pos + 1'b1;
		end
		// The line end closes whatever token is still open and clears the line.
		if (eol) begin
			if (cur_kind == OPEN_NUM) begin
				close_token(TK_NUMBER);
			end else if (cur_kind == OPEN_IDENT) begin
				close_token(TK_VARIABLE);
			end
			last_tok_char = 8'd0;
			tok_seen = 1'b0;
			col = '0;
		end
		foreach (step_recs[i]) begin
			rec = step_recs[i];
			rec.last = (i == step_recs.size() - 1);
			tokens_due.push_back(rec);
		end
	endtask

	// Sender: offers queued characters and predicts each accepted one.
	always @(posedge clk) begin
		char_item_t nxt;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				scan_char(char_code, line_end);
				n_sent <= n_sent + 1;
				if (line_end) begin
					n_lines++;
				end
			end
			if (!in_valid || !in_stall) begin
				if (chars_to_send.size() != 0 && !(tx_idle_on && hold_left == 0 &&
						$urandom_range(0, 99) < IDLE_PCT)) begin
					nxt = chars_to_send.pop_front();
					in_valid <= 1'b1;
					char_code <= nxt.ch;
					line_end <= nxt.eol;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, started once while plenty of characters are queued.
	always @(posedge clk) begin
		if (arst_n) begin
			if (!hold_done && n_sent >= 200 && chars_to_send.size() > 100) begin
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
			end
		end
	end

	task automatic check_field(input string field, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", field, want, got);
			n_errors++;
		end
	endtask

	// Receiver: compares each accepted record with the oldest prediction.
	always @(posedge clk) begin
		token_rec_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (tokens_due.size() == 0) begin
					$error("token record with none predicted: kind %0d, offset %0d",
						token_kind, start_offset);
					n_errors++;
				end else begin
					want = tokens_due.pop_front();
					check_field("token_kind", want.kind, token_kind);
					check_field("start_offset", want.start, start_offset);
					check_field("token_length", want.len, token_length);
					check_field("length_clipped", want.clip, length_clipped);
					check_field("last_of_run", want.last, last_of_run);
					n_checked++;
					if (want.clip) begin
						n_clipped++;
					end
				end
			end
			out_stall <= (hold_left != 0) || (rx_idle_on && $urandom_range(0, 99) < IDLE_PCT);
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		if (idx == CFG_DELIM) begin
			delim_code = val;
		end else if (idx == CFG_POINT) begin
			point_code = val;
		end
		n_cfg_writes++;
	endtask

	// Waits until every character is taken and every record has come out.
	task automatic drain();
		do @(posedge clk); while (chars_to_send.size() != 0 || in_valid || tokens_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic flush_line();
		char_item_t item;
		foreach (line_buf[i]) begin
			item.ch = line_buf[i];
			item.eol = (i == line_buf.size() - 1);
			chars_to_send.push_back(item);
		end
		n_items += line_buf.size();
		line_buf.delete();
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			line_buf.push_back(s[i]);
		end
	endtask

	function automatic logic [7:0] rand_letter();
		case ($urandom_range(0, 4))
			0: return CH_UNDER;
			1, 2: return CH_LC_A + 8'($urandom_range(0, 25));
			default: return CH_UC_A + 8'($urandom_range(0, 25));
		endcase
	endfunction

	function automatic logic [7:0] rand_digit();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] rand_blank();
		return ($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB;
	endfunction

	// Builds one expression-like line from random tokens, with some noise bytes.
	task automatic build_expr_line();
		string ops;
		int n_tok;
		ops = "+*/^%<>=!";
		n_tok = $urandom_range(1, 10);
		repeat (n_tok) begin
			case ($urandom_range(0, 11))
				0, 1: begin
					line_buf.push_back(($urandom_range(0, 4) == 0) ? point_code : rand_digit());
					repeat ($urandom_range(0, 4)) begin
						line_buf.push_back(($urandom_range(0, 5) == 0) ? point_code
							: rand_digit());
					end
				end
				2, 3: begin
					line_buf.push_back(rand_letter());
					repeat ($urandom_range(0, 5)) begin
						line_buf.push_back(($urandom_range(0, 2) == 0) ? rand_digit()
							: rand_letter());
					end
					if ($urandom_range(0, 2) == 0) begin
						line_buf.push_back(CH_LPAREN);
					end
				end
				4: line_buf.push_back(CH_LPAREN);
				5: line_buf.push_back(CH_RPAREN);
				6: line_buf.push_back(delim_code);
				7, 8: line_buf.push_back(CH_MINUS);
				9: line_buf.push_back(ops[$urandom_range(0, ops.len() - 1)]);
				10: begin
					repeat ($urandom_range(1, 3)) line_buf.push_back(rand_blank());
				end
				default: line_buf.push_back(8'($urandom_range(0, 255)));
			endcase
			if ($urandom_range(0, 3) == 0) begin
				line_buf.push_back(rand_blank());
			end
		end
		flush_line();
	endtask

	// Mostly well-formed lines, the rest lines of arbitrary bytes.
	task automatic run_random(input int count);
		int stop_at;
		stop_at = n_items + count;
		while (n_items < stop_at) begin
			if ($urandom_range(0, 99) < 15) begin
				repeat ($urandom_range(1, 16)) line_buf.push_back(8'($urandom_range(0, 255)));
				flush_line();
			end else begin
				build_expr_line();
			end
		end
		drain();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed lines under the reset configuration: every token kind, a function
		// call, a leading minus, extreme codes and tokens closed by the line end.
		add_text("-f_1(2.5,x)-3");
		flush_line();
		line_buf.push_back(8'h00);
		line_buf.push_back(8'hFF);
		line_buf.push_back(CH_TAB);
		line_buf.push_back(CH_MINUS);
		line_buf.push_back(CH_UC_A);
		flush_line();
		line_buf.push_back(CH_MINUS);
		flush_line();
		drain();

		run_random(200);

		// Lowest codes with no idling on either side.
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		write_reg(CFG_DELIM, 8'h00);
		write_reg(CFG_POINT, 8'h00);
		run_random(130);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;

		// Highest codes, then writes to unused indexes that must change nothing.
		write_reg(CFG_DELIM, 8'hFF);
		write_reg(CFG_POINT, 8'hFF);
		run_random(130);
		write_reg(CFG_SPARE_LO, 8'($urandom_range(0, 255)));
		write_reg(CFG_SPARE_HI, 8'($urandom_range(0, 255)));
		run_random(80);

		// Overlapping codes: minus as delimiter and a blank as the decimal point.
		write_reg(CFG_DELIM, CH_MINUS);
		write_reg(CFG_POINT, CH_SPACE);
		run_random(120);

		// Open bracket as delimiter and a letter as the decimal point.
		write_reg(CFG_DELIM, CH_LPAREN);
		write_reg(CFG_POINT, "e");
		run_random(120);

		// Back to the usual codes for tokens past the length limit.
		write_reg(CFG_DELIM, DELIM_RESET);
		write_reg(CFG_POINT, POINT_RESET);
		repeat (70) line_buf.push_back(rand_digit());
		line_buf.push_back(CH_SPACE);
		repeat (70) line_buf.push_back(rand_letter());
		line_buf.push_back(CH_LPAREN);
		line_buf.push_back(CH_RPAREN);
		flush_line();
		repeat (70) line_buf.push_back(rand_letter());
		flush_line();
		drain();

		$display("Scanned %0d characters in %0d lines; %0d token records matched.",
			n_sent, n_lines, n_checked);
		$display("Seen %0d clipped lengths and %0d register writes.",
			n_clipped, n_cfg_writes);
		if (n_errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// File: expression_token_scanner_top.f
+incdir+rtl
rtl/ets_pkg.sv
rtl/ets_resq.sv
rtl/ets_scan.sv
rtl/expression_token_scanner_top.sv
sim/tb_expression_token_scanner_top.sv
